[hw/rtl/sdfr_pkg.sv]
// Shared constants and types for the serial display frame receiver.
// Holds the header and command codes, result kinds, payload widths, the default buffer size and the sequencer states.
// No dependencies.
`default_nettype none

package sdfr_pkg;

   // Default frame buffer depth in bytes (legal range 8 to 255)
   localparam int FRAME_BUFFER_BYTES_DEF = 64;

   // Header and command codes
   localparam logic [7:0] HDR_FIRST       = 8'h5A;
   localparam logic [7:0] HDR_SECOND      = 8'hA5;
   localparam logic [7:0] CMD_VAR_REPLY   = 8'h83;
   localparam logic [7:0] CMD_CLOCK_REPLY = 8'h81;

   // Result kinds carried on tuser
   localparam logic KIND_VAR   = 1'b0;
   localparam logic KIND_CLOCK = 1'b1;

   // Payload widths
   localparam int RX_W     = 8;
   localparam int RSP_W    = 40;
   localparam int WORD_W   = 16;

   // Sequencer states, one-hot
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_READ = 4'b0010,
      ST_EMIT = 4'b0100,
      ST_VAR  = 4'b1000
   } seq_state_type;

endpackage : sdfr_pkg

`default_nettype wire

[hw/rtl/serial_display_frame_receiver.sv]
// Serial display frame receiver: header hunt, frame store and result drain.
// Depends on sdfr_pkg for codes, widths and the sequencer state type.
//
//  Channel | Dir | Ports                          | Transaction
//  --------+-----+--------------------------------+-------------------------------
//  req     | in  | req_tvalid/tready/tdata[7:0]   | one received serial byte
//  rsp     | out | rsp_tvalid/tready/tdata[39:0], | one result: var reply word pair
//          |     | rsp_tuser, rsp_tlast           | or one clock data byte
//
// A byte is taken only while the sequencer is idle.
// After its last byte a 0x83 frame enters ST_VAR, which loads the output when free.
// A 0x81 frame is drained from the frame store one body byte at a time,
// each by a memory read (ST_READ), then an output load (ST_EMIT) when free.
// Synchronous active-high reset restarts the header hunt and empties the output.
// A stalled rsp side holds the drain; bytes are still taken while only the output waits.
`default_nettype none

module serial_display_frame_receiver #(
   parameter int FRAME_BUFFER_BYTES = sdfr_pkg::FRAME_BUFFER_BYTES_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [sdfr_pkg::RX_W-1:0]   req_tdata,   // [7:0] rx_byte
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [sdfr_pkg::RSP_W-1:0]       rsp_tdata,   // [15:0] var_address,
                                                         // [31:16] var_data,
                                                         // [39:32] clock_byte
   output logic                             rsp_tuser,   // [0] kind
   output logic                             rsp_tlast    // last
);
   import sdfr_pkg::*;

   localparam int AW   = (FRAME_BUFFER_BYTES > 1) ? $clog2(FRAME_BUFFER_BYTES) : 1;
   localparam int CW   = $clog2(FRAME_BUFFER_BYTES + 1);
   localparam int CMPW = 9;
   localparam logic [CMPW-1:0] FB_CMP = CMPW'(FRAME_BUFFER_BYTES);

   // Frame store, one synchronous read port
   logic [7:0]    store_mem [FRAME_BUFFER_BYTES];
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    rd_data_ff;

   // Control state
   seq_state_type state_ff, state_in;
   logic          in_frame_ff, in_frame_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] drain_len_ff, drain_len_in;

   // Frame fields captured on the way in
   logic [7:0]        len_ff, len_in;
   logic [7:0]        cmd_ff, cmd_in;
   logic [WORD_W-1:0] var_addr_ff, var_addr_in;
   logic [WORD_W-1:0] var_data_ff, var_data_in;

   // Output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;
   logic             rsp_kind_ff, rsp_kind_in;
   logic             rsp_last_ff, rsp_last_in;

   logic            accept;
   logic            out_free;
   logic [7:0]      rx;
   logic [CW-1:0]   cnt_next;
   logic [7:0]      exp_len;
   logic [CMPW-1:0] exp_cmp;
   logic [CMPW-1:0] cnt_next_cmp;
   logic [CW-1:0]   rd_ptr_next;

   assign req_tready   = (state_ff == ST_IDLE);
   assign accept       = req_tvalid && req_tready;
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign rx           = req_tdata;
   assign cnt_next     = cnt_ff + CW'(1);
   assign cnt_next_cmp = CMPW'(cnt_next);
   // Frame length from the length byte; the current byte is the length byte at count two
   assign exp_len      = ((cnt_ff == CW'(2)) ? rx : len_ff) + 8'd3;
   assign exp_cmp      = CMPW'(exp_len);
   assign rd_ptr_next  = rd_ptr_ff + CW'(1);

   assign wr_en   = accept && in_frame_ff && (CMPW'(cnt_ff) < FB_CMP);
   assign wr_addr = cnt_ff[AW-1:0];

   // Frame parsing and drain sequencer
   always_comb begin
      state_in     = state_ff;
      in_frame_in  = in_frame_ff;
      cnt_in       = cnt_ff;
      rd_ptr_in    = rd_ptr_ff;
      drain_len_in = drain_len_ff;
      len_in       = len_ff;
      cmd_in       = cmd_ff;
      var_addr_in  = var_addr_ff;
      var_data_in  = var_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept && !in_frame_ff) begin
               // Header hunt
               if (cnt_ff == CW'(0) && rx == HDR_FIRST) begin
                  cnt_in = CW'(1);
               end else if (cnt_ff == CW'(1) && rx == HDR_SECOND) begin
                  cnt_in      = CW'(2);
                  in_frame_in = 1'b1;
               end else begin
                  cnt_in = '0;
               end
            end else if (accept) begin
               if (CMPW'(cnt_ff) >= FB_CMP) begin
                  // Store full: drop the frame
                  cnt_in      = '0;
                  in_frame_in = 1'b0;
               end else begin
                  cnt_in = cnt_next;
                  case (cnt_ff)
                     CW'(2): len_in = rx;
                     CW'(3): cmd_in = rx;
                     CW'(4): var_addr_in[15:8] = rx;
                     CW'(5): var_addr_in[7:0]  = rx;
                     CW'(6): var_data_in[15:8] = rx;
                     CW'(7): var_data_in[7:0]  = rx;
                     default: ;
                  endcase
                  if (cnt_ff == CW'(2) && exp_cmp > FB_CMP) begin
                     // Length too large for the buffer
                     cnt_in      = '0;
                     in_frame_in = 1'b0;
                  end else if (cnt_ff >= CW'(2) && cnt_next_cmp >= exp_cmp) begin
                     // Frame complete
                     cnt_in      = '0;
                     in_frame_in = 1'b0;
                     if (cmd_ff == CMD_VAR_REPLY && cnt_next >= CW'(8)) begin
                        state_in = ST_VAR;
                     end else if (cmd_ff == CMD_CLOCK_REPLY && cnt_next >= CW'(5)) begin
                        rd_ptr_in    = CW'(4);
                        drain_len_in = cnt_next;
                        state_in     = ST_READ;
                     end
                  end
               end
            end
         end
         ST_READ: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {rd_data_ff, 32'h0};
               rsp_kind_in  = KIND_CLOCK;
               rsp_last_in  = (rd_ptr_next == drain_len_ff);
               rd_ptr_in    = rd_ptr_next;
               state_in     = (rd_ptr_next == drain_len_ff) ? ST_IDLE : ST_READ;
            end
         end
         ST_VAR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {8'h0, var_data_ff, var_addr_ff};
               rsp_kind_in  = KIND_VAR;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_frame_ff  <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_frame_ff  <= in_frame_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rd_ptr_ff    <= rd_ptr_in;
      drain_len_ff <= drain_len_in;
      len_ff       <= len_in;
      cmd_ff       <= cmd_in;
      var_addr_ff  <= var_addr_in;
      var_data_ff  <= var_data_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Frame store write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= rx;
      end
   end

   // Frame store read port, registered data
   always_ff @(posedge clock) begin
      rd_data_ff <= store_mem[rd_ptr_ff[AW-1:0]];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule : serial_display_frame_receiver

`default_nettype wire

[hw/rtl/sdfr_checker.sv]
// Port-level checks for the serial display frame receiver.
// Bound to serial_display_frame_receiver; sees its ports only.
`default_nettype none

module sdfr_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata,
   input wire logic        rsp_tuser,
   input wire logic        rsp_tlast
);

   // A stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // A variable reply is always the only result of its frame
   a_var_last: assert property (@(posedge clock)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast)
      else $error("variable reply without last");

   // Fields of the other kind read as zero
   a_kind_fields: assert property (@(posedge clock)
      rsp_tvalid |-> (rsp_tuser ? (rsp_tdata[31:0] == 32'h0)
                                : (rsp_tdata[39:32] == 8'h0)))
      else $error("field of the other kind not zero");

   // Reset empties the output
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result present after reset");

endmodule : sdfr_checker

bind serial_display_frame_receiver sdfr_checker u_sdfr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for serial_display_frame_receiver: byte stream in, replies out.
// Depends on sdfr_pkg for codes and the buffer size; predicts replies in a scoreboard class.

// One expected or observed reply transaction
typedef struct {
   logic        kind;
   logic [15:0] var_address;
   logic [15:0] var_data;
   logic [7:0]  clock_byte;
   logic        last;
} reply_type;

class reply_scoreboard;
   localparam int STORE_BYTES = sdfr_pkg::FRAME_BUFFER_BYTES_DEF;

   // Receiver state mirror
   bit         in_frame;
   int         count;
   logic [7:0] store [STORE_BYTES];
   reply_type  due_replies [$];
   int         errors;

   function new();
      in_frame = 1'b0;
      count    = 0;
      errors   = 0;
   endfunction

   function int pending();
      return due_replies.size();
   endfunction

   // Advance the frame parser by one accepted byte, queue any replies it completes
   function void take_byte(logic [7:0] b);
      int        span;
      reply_type r;
      // header hunt
      if (!in_frame) begin
         if (count == 0 && b == sdfr_pkg::HDR_FIRST) begin
            store[0] = b;
            count    = 1;
         end else if (count == 1 && b == sdfr_pkg::HDR_SECOND) begin
            store[1] = b;
            count    = 2;
            in_frame = 1'b1;
         end else begin
            count = 0;
         end
         return;
      end
      // store full: drop frame
      if (count >= STORE_BYTES) begin
         count    = 0;
         in_frame = 1'b0;
         return;
      end
      store[count] = b;
      count++;
      if (count < 3)
         return;
      span = (int'(store[2]) + 3) % 256;
      if (count == 3 && span > STORE_BYTES) begin
         count    = 0;
         in_frame = 1'b0;
         return;
      end
      if (count >= span) begin
         if (count >= 8 && store[3] == sdfr_pkg::CMD_VAR_REPLY) begin
            r.kind        = sdfr_pkg::KIND_VAR;
            r.var_address = {store[4], store[5]};
            r.var_data    = {store[6], store[7]};
            r.clock_byte  = '0;
            r.last        = 1'b1;
            due_replies.push_back(r);
         end else if (count >= 5 && store[3] == sdfr_pkg::CMD_CLOCK_REPLY) begin
            for (int i = 4; i < count; i++) begin
               r.kind        = sdfr_pkg::KIND_CLOCK;
               r.var_address = '0;
               r.var_data    = '0;
               r.clock_byte  = store[i];
               r.last        = (i + 1 == count);
               due_replies.push_back(r);
            end
         end
         count    = 0;
         in_frame = 1'b0;
      end
   endfunction

   function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endfunction

   // Compare one accepted reply with the oldest expectation
   function void check_reply(reply_type got);
      reply_type want;
      if (due_replies.size() == 0) begin
         $error("reply with none expected: kind %0h byte %0h", got.kind, got.clock_byte);
         errors++;
         return;
      end
      want = due_replies.pop_front();
      compare_field("kind", 16'(want.kind), 16'(got.kind));
      compare_field("var_address", want.var_address, got.var_address);
      compare_field("var_data", want.var_data, got.var_data);
      compare_field("clock_byte", 16'(want.clock_byte), 16'(got.clock_byte));
      compare_field("last", 16'(want.last), 16'(got.last));
   endfunction
endclass

module tb;
   localparam int BUF          = sdfr_pkg::FRAME_BUFFER_BYTES_DEF;
   localparam int LONG_HOLD    = 600;
   localparam int IDLE_LIMIT   = 5000;
   localparam int DRAIN_CYCLES = 2 * BUF + 16;
   localparam int STREAM_BYTES = 320;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [7:0]  req_tdata  = '0;
   logic        rsp_tready = 1'b0;
   logic        req_tready;
   logic        rsp_tvalid;
   logic [39:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   reply_scoreboard board;
   bit              hold_request = 1'b0;
   int              stream_count;

   always #1 clock = ~clock;

   serial_display_frame_receiver #(
      .FRAME_BUFFER_BYTES(BUF)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(30, 120);
   endfunction

   // Body byte, biased toward the extremes
   function automatic logic [7:0] body_byte();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 8'h00;
      if (r == 1) return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   // Bytes after the length byte for a frame that runs to completion
   function automatic int full_tail(logic [7:0] len);
      int span;
      span = (int'(len) + 3) % 256;
      return (span > BUF || span < 3) ? 0 : int'(len);
   endfunction

   // Offer one byte and wait for the transaction
   task automatic send_byte(input logic [7:0] b, input bit gapless);
      int gap;
      gap = gapless ? 0 : pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      board.take_byte(b);
      stream_count++;
   endtask

   // Header, length, then tail bytes starting with the command
   task automatic send_frame(input logic [7:0] len, input logic [7:0] cmd, input int tail,
                             input bit gapless);
      send_byte(sdfr_pkg::HDR_FIRST, gapless);
      send_byte(sdfr_pkg::HDR_SECOND, gapless);
      send_byte(len, gapless);
      for (int i = 0; i < tail; i++)
         send_byte((i == 0) ? cmd : body_byte(), gapless);
   endtask

   // Sender idles until every expected reply is out
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Reply monitor
   always @(posedge clock) begin
      reply_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind        = rsp_tuser;
         got.var_address = rsp_tdata[15:0];
         got.var_data    = rsp_tdata[31:16];
         got.clock_byte  = rsp_tdata[39:32];
         got.last        = rsp_tlast;
         board.check_reply(got);
      end
   end

   // Watchdog on cycles with no transaction on either side
   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle = 0;
         else
            idle++;
      end
      $display("tb: errors");
      $finish;
   end

   // Reply side backpressure: calm and stalling phases, one long hold on request
   initial begin : reply_sink
      int stall;
      int phase;
      bit calm;
      bit held;
      stall = 0;
      phase = 0;
      calm  = 1'b0;
      held  = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_request && !held) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end
         if (phase == 0) begin
            calm  = ($urandom_range(0, 2) == 0);
            phase = $urandom_range(50, 300);
         end
         phase--;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0)
               stall = pick_gap();
         end
         @(negedge clock);
      end
   end

   // Stimulus
   initial begin : stimulus
      int         r;
      logic [7:0] len;
      logic [7:0] cmd;
      bit         gapless;
      bit         paused;
      board        = new();
      stream_count = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // header hunt: doubled first byte, then a plain mismatch
      send_byte(sdfr_pkg::HDR_FIRST, 1'b0);
      send_byte(sdfr_pkg::HDR_FIRST, 1'b0);
      send_byte(sdfr_pkg::HDR_SECOND, 1'b0);
      send_byte(sdfr_pkg::HDR_FIRST, 1'b0);
      send_byte(8'h00, 1'b0);
      // variable reply, all-ones address and zero data
      send_frame(8'd5, sdfr_pkg::CMD_VAR_REPLY, 1, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      // shortest clock reply
      send_frame(8'd2, sdfr_pkg::CMD_CLOCK_REPLY, 2, 1'b0);
      // length wrapping below three, then an oversize length
      send_frame(8'hFF, 8'h00, 0, 1'b0);
      send_frame(8'd62, 8'h00, 0, 1'b0);
      wait_drained();

      // largest clock reply while the reply side holds off
      stream_count = 0;
      paused       = 1'b0;
      hold_request = 1'b1;
      send_frame(8'(BUF - 3), sdfr_pkg::CMD_CLOCK_REPLY, BUF - 3, 1'b1);

      while (stream_count < STREAM_BYTES) begin
         gapless = ($urandom_range(0, 4) == 0);
         r       = $urandom_range(0, 99);
         if (r < 38) begin
            // clock reply, mostly short, sometimes too short or full size
            len = ($urandom_range(0, 14) == 0) ? 8'(BUF - 3) : 8'($urandom_range(1, 9));
            send_frame(len, sdfr_pkg::CMD_CLOCK_REPLY, int'(len), gapless);
         end else if (r < 68) begin
            // variable reply, some of them short
            len = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 4))
                                              : 8'($urandom_range(5, 9));
            send_frame(len, sdfr_pkg::CMD_VAR_REPLY, int'(len), gapless);
         end else if (r < 76) begin
            // random commands, which may include the two reply codes
            len = 8'($urandom_range(0, 10));
            cmd = 8'($urandom_range(0, 255));
            send_frame(len, cmd, int'(len), gapless);
         end else if (r < 84) begin
            // zero, wrapping and oversize lengths
            case ($urandom_range(0, 5))
               0:       len = 8'd0;
               1:       len = 8'd253;
               2:       len = 8'd254;
               3:       len = 8'd255;
               4:       len = 8'(BUF - 2);
               default: len = 8'($urandom_range(BUF - 2, 252));
            endcase
            send_frame(len, sdfr_pkg::CMD_CLOCK_REPLY, full_tail(len), gapless);
         end else if (r < 92) begin
            // truncated frame, the next one runs into its body
            len = 8'($urandom_range(4, 12));
            cmd = $urandom_range(0, 1) ? sdfr_pkg::CMD_CLOCK_REPLY : sdfr_pkg::CMD_VAR_REPLY;
            send_frame(len, cmd, $urandom_range(0, int'(len) - 1), gapless);
         end else begin
            // line noise and half headers
            if ($urandom_range(0, 1) == 1)
               send_byte(sdfr_pkg::HDR_FIRST, gapless);
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), gapless);
         end
         if (!paused && stream_count >= STREAM_BYTES / 2) begin
            paused = 1'b1;
            wait_drained();
         end
      end

      wait_drained();
      if (board.errors == 0 && board.pending() == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end
endmodule
